>>> sv/sorted_list_table_defines.svh
// Assertion macros shared by the sorted list table RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/slt_pkg.sv
// Shared constants for the sorted list table: capacity, derived widths
// and status codes. No dependencies.
package slt_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW       = $clog2(CAPACITY + 1);

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

endpackage

>>> sv/slt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/sorted_list_table.sv
// Top level of the sorted list table: sequencer, entry comparators and output register.
// Depends on slt_pkg, slt_ram and sorted_list_table_defines.svh.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, mode, value           | in
//  output  | out_valid, out_ready, status, entry_count,| out
//          | smallest, largest                         |
//
// An insert reads and moves each stored entry not below the new value, then reads the
// first entry below it unless it lands at position zero; a delete reads every stored
// entry; a refused transaction (full or empty table) skips the walk.
// Each entry compared or moved takes a RAM read state and then a compare state.
// Reset clears only control state and the count; only positions below it are used.
// A waiting result does not block input; the next result stalls in its final state.
module sorted_list_table
	import slt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [4:0]               entry_count,
	output logic signed [DATA_W-1:0] smallest,
	output logic signed [DATA_W-1:0] largest
);

`include "sorted_list_table_defines.svh"

	// Sequencer states.
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_RD  = 4'd1;
	localparam logic [3:0] S_INS_CMP = 4'd2;
	localparam logic [3:0] S_DEL_RD  = 4'd3;
	localparam logic [3:0] S_DEL_CMP = 4'd4;
	localparam logic [3:0] S_DEL_END = 4'd5;
	localparam logic [3:0] S_MINMAX  = 4'd6;
	localparam logic [3:0] S_LO      = 4'd7;
	localparam logic [3:0] S_HI      = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	logic [3:0]               state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            idx_q;
	logic                     found_q;
	logic [1:0]               stat_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] lo_q;
	logic signed [DATA_W-1:0] hi_q;

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic [4:0]               count_out_q;
	logic signed [DATA_W-1:0] smallest_q;
	logic signed [DATA_W-1:0] largest_q;

	// RAM port signals.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic [CW-1:0] idx_m1;
	logic [CW-1:0] cnt_m1;
	logic          not_below;   // insert comparator: stored entry >= value
	logic          is_equal;
	logic          in_acc;
	logic          out_load;

	assign idx_m1    = idx_q - CW'(1);
	assign cnt_m1    = count_q - CW'(1);
	assign not_below = $signed(ram_rdata) >= val_q;
	assign is_equal  = ram_rdata == val_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	slt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// RAM access for each state. An insert walks down from the top, moving
	// every entry that is not below the new value one place up. A delete
	// walks up from the bottom and, once the match is found, moves each later
	// entry one place down over it.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = val_q;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_INS_RD: begin
				if (idx_q == '0) begin
					ram_we = 1'b1;
				end
				ram_raddr = idx_m1[AW-1:0];
			end
			S_INS_CMP: begin
				ram_we = 1'b1;
				if (not_below) begin
					ram_wdata = ram_rdata;
				end
			end
			S_DEL_CMP: begin
				if (found_q) begin
					ram_we    = 1'b1;
					ram_waddr = idx_m1[AW-1:0];
					ram_wdata = ram_rdata;
				end
			end
			S_MINMAX: begin
				ram_raddr = '0;
			end
			S_LO: begin
				ram_raddr = cnt_m1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			stat_q  <= ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						found_q <= 1'b0;
						stat_q  <= ST_DONE;
						if (mode == MODE_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								stat_q  <= ST_FULL;
								state_q <= S_MINMAX;
							end else begin
								idx_q   <= count_q;
								state_q <= S_INS_RD;
							end
						end else begin
							if (count_q == '0) begin
								stat_q  <= ST_EMPTY;
								state_q <= S_MINMAX;
							end else begin
								idx_q   <= '0;
								state_q <= S_DEL_RD;
							end
						end
					end
				end
				S_INS_RD: begin
					if (idx_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= S_MINMAX;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (not_below) begin
						idx_q   <= idx_m1;
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_MINMAX;
					end
				end
				S_DEL_RD: begin
					if (idx_q == count_q) begin
						state_q <= S_DEL_END;
					end else begin
						state_q <= S_DEL_CMP;
					end
				end
				S_DEL_CMP: begin
					if (!found_q && is_equal) begin
						found_q <= 1'b1;
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_DEL_RD;
				end
				S_DEL_END: begin
					if (found_q) begin
						count_q <= cnt_m1;
					end else begin
						stat_q <= ST_NOT_FOUND;
					end
					state_q <= S_MINMAX;
				end
				S_MINMAX: begin
					if (count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LO;
					end
				end
				S_LO: begin
					state_q <= S_HI;
				end
				S_HI: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers for the transaction in progress.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q <= value;
		end
		if (state_q == S_MINMAX) begin
			lo_q <= '0;
			hi_q <= '0;
		end
		if (state_q == S_LO) begin
			lo_q <= ram_rdata;
		end
		if (state_q == S_HI) begin
			hi_q <= ram_rdata;
		end
	end

	// Output register: holds one finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= stat_q;
			count_out_q <= 5'(count_q);
			smallest_q  <= lo_q;
			largest_q   <= hi_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = count_out_q;
	assign smallest    = smallest_q;
	assign largest     = largest_q;

	// The count never passes the capacity.
	`SLT_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	// The insert walk never compares below position zero.
	`SLT_ASSERT_NOW(a_ins_idx, state_q == S_INS_CMP, idx_q != '0, "insert index underflow")
	// The delete walk never runs past the stored entries.
	`SLT_ASSERT_NOW(a_del_idx, state_q == S_DEL_RD, idx_q <= count_q, "delete index overrun")
	// A full status is only reported with a full table.
	`SLT_ASSERT_NEXT(a_full, out_load && stat_q == ST_FULL, count_q == CW'(CAPACITY),
		"full status with free room")

endmodule

>>> bench/sorted_list_table_tb.sv
// Self-checking testbench for sorted_list_table: drives insert and delete transactions,
// predicts status, count, smallest and largest, and checks every result in order.
// Depends on slt_pkg and the sorted_list_table RTL.
`timescale 1ns / 1ps

typedef struct packed {
	logic [1:0]         status;
	logic [4:0]         count;
	logic signed [31:0] lo;
	logic signed [31:0] hi;
} table_result_t;

// Mirror of the table contents plus the queue of results still owed by the block.
class sorted_table_tracker;
	logic signed [31:0] stored[$];
	table_result_t      pending_results[$];
	int                 error_count;
	int                 reported;
	int                 results_checked;
	int                 inserts;
	int                 deletes;
	int                 peak_depth;
	int                 status_seen[4];

	// Apply one accepted transaction to the mirror and queue the result it owes.
	function void note_input(logic m, logic signed [31:0] v);
		table_result_t r;
		int            pos;
		pos = 0;
		r.status = slt_pkg::ST_DONE;
		if (m == slt_pkg::MODE_INSERT) begin
			inserts++;
			if (stored.size() >= slt_pkg::CAPACITY) begin
				r.status = slt_pkg::ST_FULL;
			end else begin
				// The new value goes ahead of any equal entries.
				while (pos < stored.size() && v > stored[pos])
					pos++;
				stored.insert(pos, v);
			end
		end else begin
			deletes++;
			if (stored.size() == 0) begin
				r.status = slt_pkg::ST_EMPTY;
			end else begin
				while (pos < stored.size() && stored[pos] != v)
					pos++;
				if (pos == stored.size())
					r.status = slt_pkg::ST_NOT_FOUND;
				else
					stored.delete(pos);
			end
		end
		r.count = 5'(stored.size());
		r.lo    = (stored.size() > 0) ? stored[0] : '0;
		r.hi    = (stored.size() > 0) ? stored[stored.size() - 1] : '0;
		if (stored.size() > peak_depth)
			peak_depth = stored.size();
		status_seen[r.status]++;
		pending_results.push_back(r);
	endfunction

	function void check_result(table_result_t got);
		table_result_t want;
		if (pending_results.size() == 0) begin
			error_count++;
			if (reported < 10)
				$display("[%0t] unexpected result: status=%0d count=%0d lo=%0d hi=%0d",
					$realtime, got.status, got.count, got.lo, got.hi);
			reported++;
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (got.status !== want.status || got.count !== want.count ||
		    got.lo !== want.lo || got.hi !== want.hi) begin
			error_count++;
			if (reported < 10) begin
				$display("[%0t] mismatch on result %0d:", $realtime, results_checked);
				$display("   expected status=%0d count=%0d lo=%0d hi=%0d",
					want.status, want.count, want.lo, want.hi);
				$display("   actual   status=%0d count=%0d lo=%0d hi=%0d",
					got.status, got.count, got.lo, got.hi);
			end
			reported++;
		end
	endfunction
endclass

module sorted_list_table_tb;
	import slt_pkg::*;

	// The limit is several times the worst case per item (busy time, a receiver stall and
	// a sender gap) summed over the whole run.
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 800;
	localparam int PHASE_ITEMS   = 100;
	localparam int DRAIN_CYCLES  = 60;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic                     mode        = MODE_INSERT;
	logic signed [DATA_W-1:0] value       = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic [1:0]               status;
	logic [4:0]               entry_count;
	logic signed [DATA_W-1:0] smallest;
	logic signed [DATA_W-1:0] largest;

	int                  cycle_count = 0;
	sorted_table_tracker tracker     = new();

	sorted_list_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_count (entry_count),
		.smallest    (smallest),
		.largest     (largest)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// The watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding.",
			cycle_count, tracker.pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Result side. Values read right after the edge are the ones the block presented at
	// that edge, since all of its registers update later in the time step. The ready
	// pattern rotates and is replaced when pattern_age wraps; a quarter of the patterns
	// never stall, and every pattern has at least one high bit so a stall always ends.
	logic [15:0] ready_pattern = 16'hffff;
	int          pattern_age   = 0;

	always @(posedge clk) begin
		table_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.count  = entry_count;
			got.lo     = smallest;
			got.hi     = largest;
			tracker.check_result(got);
		end
		if (pattern_age == 199) begin
			pattern_age   <= 0;
			ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h1);
		end else begin
			pattern_age   <= pattern_age + 1;
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
		end
		out_ready <= ready_pattern[0];
	end

	// Present one transaction and hold it until the block takes it. The caller is
	// always at a rising edge, so valid stays high across back-to-back items.
	task automatic push_item(input logic m, input logic signed [DATA_W-1:0] v);
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.note_input(m, v);
	endtask

	task automatic idle_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Values are drawn mostly from a narrow band so that duplicates and hits are common;
	// deletes prefer a value actually stored so that they reach deep into the table.
	function automatic logic signed [DATA_W-1:0] pick_value(input bit for_delete);
		int sel;
		int n;
		int band;
		sel  = $urandom_range(0, 99);
		n    = tracker.stored.size();
		band = $urandom_range(0, 8);
		if (for_delete && n > 0 && sel < 60)
			return tracker.stored[$urandom_range(0, n - 1)];
		if (sel < 70)
			return band - 4;
		if (sel < 82) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh8000_0001;
				default: return 32'sh7fff_fffe;
			endcase
		end
		return $urandom;
	endfunction

	int insert_pct[8] = '{90, 50, 15, 75, 5, 95, 50, 30};

	initial begin
		int  sent;
		int  burst;
		int  gap;
		bit  do_delete;
		logic signed [DATA_W-1:0] fill_values[13];

		fill_values = '{32'sh8000_0000, 32'sh7fff_ffff, 5, -5, 5, 100000, -100000,
			32'sh8000_0001, 32'sh7fff_fffe, 1, 1, -2, 42};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: empty-table delete, removing the only entry, the signed extremes,
		// an equal value inserted ahead of its twin, a miss, removal of both ends, then a
		// fill to capacity followed by a refused insert.
		push_item(MODE_DELETE, 5);
		push_item(MODE_INSERT, 7);
		push_item(MODE_DELETE, 7);
		idle_sender(3);
		push_item(MODE_INSERT, 32'sh7fff_ffff);
		push_item(MODE_INSERT, 32'sh8000_0000);
		push_item(MODE_INSERT, 0);
		push_item(MODE_INSERT, -1);
		push_item(MODE_INSERT, 0);
		push_item(MODE_DELETE, 12345);
		push_item(MODE_DELETE, 32'sh8000_0000);
		push_item(MODE_DELETE, 32'sh7fff_ffff);
		foreach (fill_values[i])
			push_item(MODE_INSERT, fill_values[i]);
		push_item(MODE_INSERT, 9);
		idle_sender(5);

		// Random part in phases whose insert share swings between filling and draining,
		// so the table passes through empty, full and everything between.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				do_delete = ($urandom_range(0, 99) >= insert_pct[sent / PHASE_ITEMS]);
				push_item(do_delete ? MODE_DELETE : MODE_INSERT, pick_value(do_delete));
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0)
				idle_sender(gap);
		end
		in_valid <= 1'b0;

		while (tracker.pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.pending_results.size() > 0)
			tracker.error_count++;
		if (tracker.error_count > 10)
			$display("%0d further errors were counted but not shown.",
				tracker.error_count - 10);

		$display("Covered %0d inserts and %0d deletes, %0d results checked, table depth up to %0d.",
			tracker.inserts, tracker.deletes, tracker.results_checked, tracker.peak_depth);
		$display("Outcomes: %0d done, %0d not found, %0d empty, %0d full; %0d errors.",
			tracker.status_seen[ST_DONE], tracker.status_seen[ST_NOT_FOUND],
			tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_FULL],
			tracker.error_count);
		if (tracker.error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> files.f
+incdir+sv
sv/slt_pkg.sv
sv/slt_ram.sv
sv/sorted_list_table.sv
bench/sorted_list_table_tb.sv
